[hdl/ecwr_pkg.sv]
// Shared types and constants of the echo-confirmed word receiver.
// Request and response payload structs, op and kind codes, register indexes.
// No dependencies.
package ecwr_pkg;

   // Transfer limits
   localparam int unsigned MAX_PAYLOAD = 64;
   localparam int unsigned WORD_BYTES  = 4;
   localparam int unsigned RSP_SLOTS   = 6;
   localparam int unsigned SLOT_CNT_W  = $clog2(RSP_SLOTS + 1);

   // Request op codes
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_BYTE  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // Response kind codes
   localparam logic [1:0] KIND_TX    = 2'd0;
   localparam logic [1:0] KIND_STORE = 2'd1;
   localparam logic [1:0] KIND_OK    = 2'd2;
   localparam logic [1:0] KIND_FAIL  = 2'd3;

   // Configuration register indexes
   localparam logic [2:0] REG_ACK_CODE     = 3'd0;
   localparam logic [2:0] REG_NAK_CODE     = 3'd1;
   localparam logic [2:0] REG_STEP_TIMEOUT = 3'd2;
   localparam logic [2:0] REG_MAX_RETRIES  = 3'd3;
   localparam logic [2:0] REG_ABORT_TMO    = 3'd4;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] rx_byte;
      logic [6:0] payload_length;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] value;
      logic [5:0] byte_index;
      logic       last;
   } rsp_type;

endpackage

[hdl/ecwr_result_queue.sv]
// Response buffer: loaded with up to RSP_SLOTS responses at once, drained one a cycle
// while rsp_ready is high. Depends on ecwr_pkg.
module ecwr_result_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic [2:0]          load_count,
   input  ecwr_pkg::rsp_type   load_items [ecwr_pkg::RSP_SLOTS],
   output logic                free,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ecwr_pkg::rsp_type   rsp_data
);
   import ecwr_pkg::*;

   rsp_type               slot_ff [RSP_SLOTS];
   logic [SLOT_CNT_W-1:0] cnt_ff;
   logic                  pop;

   assign rsp_valid = (cnt_ff != '0);
   assign rsp_data  = slot_ff[0];
   assign pop       = rsp_valid && rsp_ready;
   // Free for a new load when empty or when the last response leaves now
   assign free      = (cnt_ff == '0) || (cnt_ff == SLOT_CNT_W'(1) && pop);

   // Count the queued responses
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (load) begin
         cnt_ff <= SLOT_CNT_W'(load_count);
      end else if (pop) begin
         cnt_ff <= cnt_ff - SLOT_CNT_W'(1);
      end
   end

   // Load all slots, or advance the line toward the head
   always_ff @(posedge clock) begin
      for (int j = 0; j < RSP_SLOTS; j++) begin
         if (load) begin
            slot_ff[j] <= load_items[j];
         end else if (pop && j < RSP_SLOTS - 1) begin
            slot_ff[j] <= slot_ff[j + 1];
         end
      end
   end

endmodule

[hdl/echo_confirmed_word_receiver.sv]
// Echo-confirmed word receiver, top level.
// Depends on ecwr_pkg and ecwr_result_queue.
//
// Usage:
//   Requests arrive on req_valid/req_ready/req_data: start a payload, deliver one
//   received link byte, or signal one millisecond tick. Each request yields zero to
//   six responses on rsp_valid/rsp_ready/rsp_data, the final one flagged by last.
//   Responses are bytes to transmit (word echo, ACK, NAK), stored payload bytes
//   with their offsets, and a done-ok or done-failed mark.
//   Registers are written through csr_we/csr_index/csr_wdata by the user only
//   while idle; the block itself does not enforce this.
// Timing:
//   A request is registered at acceptance and processed in the next cycle, once the
//   response buffer is free; its first response is shown the cycle after. The buffer
//   drains one entry per cycle while rsp_ready is high and frees as its last leaves.
// Reset:
//   Synchronous reset idles the receiver, empties the buffer and restores the
//   register defaults. Word bytes are not cleared.
// Stall:
//   When rsp_ready is low the buffer holds; one further request waits in the
//   input register, then req_ready drops until the buffer frees.
module echo_confirmed_word_receiver (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ecwr_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ecwr_pkg::rsp_type  rsp_data,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);
   import ecwr_pkg::*;

   // Configuration registers
   logic [7:0]  ack_code_ff;
   logic [7:0]  nak_code_ff;
   logic [15:0] step_timeout_ff;
   logic [7:0]  max_retries_ff;
   logic [7:0]  abort_tmo_ff;

   // Input register
   req_type     in_ff;
   logic        in_valid_ff;

   // Transfer state
   logic        active_ff,  active_in;
   logic [2:0]  phase_ff,   phase_in;
   logic [7:0]  bytes_ff [WORD_BYTES];
   logic [7:0]  bytes_in [WORD_BYTES];
   logic [6:0]  offset_ff,  offset_in;
   logic [6:0]  total_ff,   total_in;
   logic [7:0]  tries_ff,   tries_in;
   logic [7:0]  trow_ff,    trow_in;
   logic [15:0] wait_ff,    wait_in;

   // Processing signals
   logic        proc;
   logic        q_free;
   rsp_type     items [RSP_SLOTS];
   logic [2:0]  n_items;
   logic [6:0]  len_sat;
   logic [6:0]  remain;
   logic [2:0]  store;
   logic [15:0] limit;
   logic [15:0] wait_inc;

   assign proc      = in_valid_ff && q_free;
   assign req_ready = !in_valid_ff || proc;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ack_code_ff     <= 8'd6;
         nak_code_ff     <= 8'd21;
         step_timeout_ff <= 16'd100;
         max_retries_ff  <= 8'd5;
         abort_tmo_ff    <= 8'd3;
      end else if (csr_we) begin
         case (csr_index)
            REG_ACK_CODE:     ack_code_ff     <= csr_wdata[7:0];
            REG_NAK_CODE:     nak_code_ff     <= csr_wdata[7:0];
            REG_STEP_TIMEOUT: step_timeout_ff <= csr_wdata;
            REG_MAX_RETRIES:  max_retries_ff  <= csr_wdata[7:0];
            REG_ABORT_TMO:    abort_tmo_ff    <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Hold the accepted request until it is processed
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (proc) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
   end

   // Advance transfer state when a request is processed
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         phase_ff  <= '0;
         offset_ff <= '0;
         total_ff  <= '0;
         tries_ff  <= '0;
         trow_ff   <= '0;
         wait_ff   <= '0;
      end else if (proc) begin
         active_ff <= active_in;
         phase_ff  <= phase_in;
         offset_ff <= offset_in;
         total_ff  <= total_in;
         tries_ff  <= tries_in;
         trow_ff   <= trow_in;
         wait_ff   <= wait_in;
      end
   end

   always_ff @(posedge clock) begin
      if (proc) begin
         bytes_ff <= bytes_in;
      end
   end

   // Next state and the response list for the held request
   always_comb begin
      active_in = active_ff;
      phase_in  = phase_ff;
      bytes_in  = bytes_ff;
      offset_in = offset_ff;
      total_in  = total_ff;
      tries_in  = tries_ff;
      trow_in   = trow_ff;
      wait_in   = wait_ff;
      n_items   = '0;
      for (int j = 0; j < RSP_SLOTS; j++) begin
         items[j] = '0;
      end

      len_sat  = ({25'd0, in_ff.payload_length} > MAX_PAYLOAD) ?
                 7'(MAX_PAYLOAD) : in_ff.payload_length;
      remain   = total_ff - offset_ff;
      store    = (remain > 7'd4) ? 3'd4 : remain[2:0];
      limit    = (step_timeout_ff == '0) ? 16'd1 : step_timeout_ff;
      wait_inc = wait_ff + 16'd1;

      case (in_ff.op)
         OP_START: begin
            active_in = (len_sat != '0);
            total_in  = len_sat;
            offset_in = '0;
            phase_in  = '0;
            tries_in  = '0;
            trow_in   = '0;
            wait_in   = '0;
            if (len_sat == '0) begin
               items[0].kind = KIND_OK;
               n_items       = 3'd1;
            end
         end
         OP_BYTE: begin
            if (active_ff) begin
               wait_in = '0;
               if (phase_ff < 3'd4) begin
                  // Collect the byte; echo the word once complete
                  bytes_in[phase_ff[1:0]] = in_ff.rx_byte;
                  phase_in = phase_ff + 3'd1;
                  if (phase_ff == 3'd3) begin
                     for (int j = 0; j < WORD_BYTES - 1; j++) begin
                        items[j].kind  = KIND_TX;
                        items[j].value = bytes_ff[j];
                     end
                     items[WORD_BYTES-1].kind  = KIND_TX;
                     items[WORD_BYTES-1].value = in_ff.rx_byte;
                     n_items = 3'(WORD_BYTES);
                  end
               end else if (in_ff.rx_byte == ack_code_ff) begin
                  // Store the valid bytes, acknowledge, advance
                  for (int j = 0; j < WORD_BYTES; j++) begin
                     if (3'(j) < store) begin
                        items[j].kind       = KIND_STORE;
                        items[j].value      = bytes_ff[j];
                        items[j].byte_index = 6'(offset_ff + 7'(j));
                     end
                  end
                  items[store].kind  = KIND_TX;
                  items[store].value = ack_code_ff;
                  n_items   = store + 3'd1;
                  offset_in = offset_ff + {4'd0, store};
                  trow_in   = '0;
                  tries_in  = '0;
                  phase_in  = '0;
                  if (remain <= 7'd4) begin
                     items[3'(store + 3'd1)].kind = KIND_OK;
                     n_items   = store + 3'd2;
                     active_in = 1'b0;
                  end
               end else begin
                  // Reject the word and count the try
                  items[0].kind  = KIND_TX;
                  items[0].value = nak_code_ff;
                  n_items  = 3'd1;
                  phase_in = '0;
                  tries_in = tries_ff + 8'd1;
                  if (tries_in >= max_retries_ff) begin
                     items[1].kind = KIND_FAIL;
                     n_items   = 3'd2;
                     active_in = 1'b0;
                  end
               end
            end
         end
         OP_TICK: begin
            if (active_ff) begin
               if (wait_inc >= limit) begin
                  // Restart the word; either limit fails the transfer
                  wait_in  = '0;
                  phase_in = '0;
                  trow_in  = trow_ff + 8'd1;
                  if (trow_in >= abort_tmo_ff) begin
                     items[0].kind = KIND_FAIL;
                     n_items   = 3'd1;
                     active_in = 1'b0;
                  end else begin
                     tries_in = tries_ff + 8'd1;
                     if (tries_in >= max_retries_ff) begin
                        items[0].kind = KIND_FAIL;
                        n_items   = 3'd1;
                        active_in = 1'b0;
                     end
                  end
               end else begin
                  wait_in = wait_inc;
               end
            end
         end
         default: ;
      endcase

      // Flag the final response of this request
      for (int j = 0; j < RSP_SLOTS; j++) begin
         items[j].last = (n_items == 3'(j + 1));
      end
   end

   ecwr_result_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .load       (proc),
      .load_count (n_items),
      .load_items (items),
      .free       (q_free),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
